>>> rtl/bls_pkg.sv
package bls_pkg;

    // coordinate width of the raster
    localparam int COORD_BITS = 10;
    // signed decision variable width
    localparam int ERR_BITS = COORD_BITS + 3;
    // command queue between front and back
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);

    typedef logic [COORD_BITS-1:0] t_coord;

    // func field codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    // per-axis step: +1, -1 or 0 in two's complement
    typedef enum logic [1:0] {
        DIR_ZERO = 2'b00,
        DIR_INC  = 2'b01,
        DIR_DEC  = 2'b11
    } t_dir;

    typedef struct packed {
        logic   func;
        t_coord x_start;
        t_coord y_start;
        t_coord x_end;
        t_coord y_end;
    } t_in_item;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   last;
    } t_out_item;

    // classified command handed from front to back
    typedef struct packed {
        t_op    op;
        t_coord x_start;
        t_coord y_start;
        t_coord dx;
        t_coord dy;
        t_dir   dir_x;
        t_dir   dir_y;
    } t_cmd;

    // move a coordinate one step, wrapping at the raster width
    function automatic t_coord move_coord(input t_coord v, input t_dir d);
        t_coord r;
        unique case (d)
            DIR_INC:  r = v + t_coord'(1);
            DIR_DEC:  r = v - t_coord'(1);
            DIR_ZERO: r = v;
            default:  r = v;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/bresenham_line_stepper.sv
// Path: a step item is written into the command queue, then the stepper takes it
// and registers its pixel in its output register, from which it shows on o_item.
// Throughput: one item per cycle while not full and the output drains; each step
// is one add, compare, subtract; a 4-entry queue decouples intake from output.
// Reset: synchronous, active low; clears queue, line state and output valid.
module bresenham_line_stepper import bls_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;
    logic out_valid;

    // front: accept and classify items
    bls_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    // back: line state and pixel output
    bls_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .o_out_valid (out_valid),
        .i_out_pop   (pop),
        .o_out       (o_item)
    );

    assign empty = !out_valid;

endmodule

>>> rtl/bls_front.sv
module bls_front import bls_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_item i_item,
    output logic     o_cmd_valid,
    input  logic     i_cmd_pop,
    output t_cmd     o_cmd
);

    t_cmd                  r_mem [CMD_DEPTH];
    logic [CMD_PTR_BITS-1:0] r_wptr, n_wptr;
    logic [CMD_PTR_BITS-1:0] r_rptr, n_rptr;
    logic [CMD_PTR_BITS:0]   r_count, n_count;
    logic                  wr_en;
    logic                  rd_en;
    t_cmd                  cmd_in;

    // classify: deltas and step directions per axis
    always_comb begin
        cmd_in.op      = (i_item.func == FUNC_STEP) ? OP_STEP : OP_LOAD;
        cmd_in.x_start = i_item.x_start;
        cmd_in.y_start = i_item.y_start;
        if (i_item.x_end >= i_item.x_start) begin
            cmd_in.dx = i_item.x_end - i_item.x_start;
        end else begin
            cmd_in.dx = i_item.x_start - i_item.x_end;
        end
        if (i_item.y_end >= i_item.y_start) begin
            cmd_in.dy = i_item.y_end - i_item.y_start;
        end else begin
            cmd_in.dy = i_item.y_start - i_item.y_end;
        end
        priority if (i_item.x_end > i_item.x_start) begin
            cmd_in.dir_x = DIR_INC;
        end else if (i_item.x_end < i_item.x_start) begin
            cmd_in.dir_x = DIR_DEC;
        end else begin
            cmd_in.dir_x = DIR_ZERO;
        end
        priority if (i_item.y_end > i_item.y_start) begin
            cmd_in.dir_y = DIR_INC;
        end else if (i_item.y_end < i_item.y_start) begin
            cmd_in.dir_y = DIR_DEC;
        end else begin
            cmd_in.dir_y = DIR_ZERO;
        end
    end

    // queue pointers and fill count
    assign full        = (r_count == (CMD_PTR_BITS+1)'(CMD_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign wr_en       = push && !full;
    assign rd_en       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_mem[r_rptr];

    always_comb begin
        n_wptr  = wr_en ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = rd_en ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= cmd_in;
        end
    end

endmodule

>>> rtl/bls_engine.sv
module bls_engine import bls_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_pop,
    input  t_cmd      i_cmd,
    output logic      o_out_valid,
    input  logic      i_out_pop,
    output t_out_item o_out
);

    t_coord                    r_cur_x, n_cur_x;
    t_coord                    r_cur_y, n_cur_y;
    logic signed [ERR_BITS-1:0] r_err, n_err;
    t_coord                    r_left, n_left;
    t_coord                    r_major, n_major;
    t_coord                    r_minor, n_minor;
    t_dir                      r_dir_x, n_dir_x;
    t_dir                      r_dir_y, n_dir_y;
    logic                      r_swapped, n_swapped;
    logic                      r_out_valid, n_out_valid;
    t_out_item                 r_out, n_out;
    logic                      take;
    logic                      swap;
    t_coord                    ld_major;
    t_coord                    ld_minor;
    logic signed [ERR_BITS-1:0] two_minor;
    logic signed [ERR_BITS-1:0] two_major;
    logic signed [ERR_BITS-1:0] corr;

    assign take        = i_cmd_valid && (!r_out_valid || i_out_pop);
    assign o_cmd_pop   = take;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // load path: pick major axis
    assign swap     = (i_cmd.dy > i_cmd.dx);
    assign ld_major = swap ? i_cmd.dy : i_cmd.dx;
    assign ld_minor = swap ? i_cmd.dx : i_cmd.dy;

    // step path: doubled deltas
    assign two_minor = {2'b00, r_minor, 1'b0};
    assign two_major = {2'b00, r_major, 1'b0};
    assign corr      = (r_err > 0) ? two_major : '0;

    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_err       = r_err;
        n_left      = r_left;
        n_major     = r_major;
        n_minor     = r_minor;
        n_dir_x     = r_dir_x;
        n_dir_y     = r_dir_y;
        n_swapped   = r_swapped;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_pop;
        if (take) begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    n_major   = ld_major;
                    n_minor   = ld_minor;
                    n_swapped = swap;
                    n_dir_x   = i_cmd.dir_x;
                    n_dir_y   = i_cmd.dir_y;
                    n_cur_x   = i_cmd.x_start;
                    n_cur_y   = i_cmd.y_start;
                    n_left    = ld_major;
                    n_err     = $signed({2'b00, ld_minor, 1'b0})
                              - $signed({3'b000, ld_major});
                end
                OP_STEP: begin
                    // no line active: item gives nothing
                    if (r_left != '0) begin
                        n_out_valid   = 1'b1;
                        n_out.pixel_x = r_cur_x;
                        n_out.pixel_y = r_cur_y;
                        n_out.last    = (r_left == t_coord'(1));
                        if (r_swapped) begin
                            n_cur_y = move_coord(r_cur_y, r_dir_y);
                            if (r_err > 0) begin
                                n_cur_x = move_coord(r_cur_x, r_dir_x);
                            end
                        end else begin
                            n_cur_x = move_coord(r_cur_x, r_dir_x);
                            if (r_err > 0) begin
                                n_cur_y = move_coord(r_cur_y, r_dir_y);
                            end
                        end
                        n_err  = r_err + two_minor - corr;
                        n_left = r_left - t_coord'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // line state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_err       <= '0;
            r_left      <= '0;
            r_major     <= '0;
            r_minor     <= '0;
            r_dir_x     <= DIR_ZERO;
            r_dir_y     <= DIR_ZERO;
            r_swapped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_err       <= n_err;
            r_left      <= n_left;
            r_major     <= n_major;
            r_minor     <= n_minor;
            r_dir_x     <= n_dir_x;
            r_dir_y     <= n_dir_y;
            r_swapped   <= n_swapped;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule
